// ===== hw/rtl/ed_pkg.sv =====
// Shared types and constants for the euclidean_distance block.
// No dependencies; used by ed_sqrt and euclidean_distance.
package ed_pkg;

  // Result width of the distance field, unsigned Q16.8.
  localparam int unsigned DIST_W = 24;

  // Status of the iterative square-root unit.
  typedef struct packed {
    logic busy;  // iterations in progress
    logic done;  // one-cycle pulse after the final iteration
  } sqrt_stat_t;

endpackage

// ===== hw/rtl/euclidean_distance.sv =====
// Streaming L2 distance between two signed fixed-point vectors.
// Depends on ed_pkg (types, constants) and ed_sqrt (iterative root unit).
//
//  channel  | direction | fields
//  ---------+-----------+--------------------------------------------------
//  s_axis   | in        | tdata: a_value, b_value (Q8.8); tlast: last
//  m_axis   | out       | tdata: distance (Q16.8); tuser: saturated
//
// Steps: a pair with last low passes accept, square and accumulate, and the
// next pair is taken only once the sequencer is back in idle. A pair with last
// high adds the root: (ACC_WIDTH+1)/2 iterations of the one-bit-per-cycle root
// unit, then a handoff through the root-wait and emit states.
// Reset: rst_ni clears the control state, the running sum and the flag.
// Stalls: a result waits in the output register; the next request is taken
// meanwhile, and only the emit step holds while that register is still full.
module euclidean_distance #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned ACC_WIDTH    = 48
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // slave side
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [SAMPLE_WIDTH-1:0] a_value, [2*SAMPLE_WIDTH-1:SAMPLE_WIDTH] b_value, zero pad
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
  input  logic                                  s_axis_tlast,
  // master side
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [23:0] distance
  output logic [ed_pkg::DIST_W-1:0]             m_axis_tdata,
  // [0] saturated
  output logic                                  m_axis_tuser
);

  localparam int unsigned SW    = SAMPLE_WIDTH;
  localparam int unsigned RW    = (ACC_WIDTH + 1) / 2;
  localparam int unsigned SUM_W = ((ACC_WIDTH > 2*SW) ? ACC_WIDTH : 2*SW) + 1;
  localparam int unsigned DW    = ed_pkg::DIST_W;

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SQUARE = 3'd1;
  localparam logic [2:0] ST_ACCUM  = 3'd2;
  localparam logic [2:0] ST_ROOT   = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0]           state_q, state_d;
  logic signed [SW:0]   diff_q, diff_d;
  logic                 last_q;
  logic [2*SW-1:0]      sq_q, sq_d;
  logic [ACC_WIDTH-1:0] acc_q, acc_d;
  logic                 ovf_q, ovf_d;
  logic                 out_valid_q, out_valid_d;
  logic [DW-1:0]        dist_q;
  logic                 sat_q;

  logic                 in_fire;
  logic                 emit_fire;
  logic [SW-1:0]        a_val, b_val;
  logic [SW:0]          diff_neg;
  logic [SW-1:0]        mag;
  logic [SUM_W-1:0]     sum_ext;
  logic                 sum_ovf;
  logic                 sqrt_start;
  ed_pkg::sqrt_stat_t   sqrt_stat;
  logic [RW-1:0]        root;
  logic [DW-1:0]        dist_clamped;
  logic                 root_clamp;

  // ---------------------------------------------------------------------
  // Input capture: take the difference at once, the pair is not kept.
  // ---------------------------------------------------------------------
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign a_val  = s_axis_tdata[SW-1:0];
  assign b_val  = s_axis_tdata[2*SW-1:SW];
  assign diff_d = $signed({a_val[SW-1], a_val}) - $signed({b_val[SW-1], b_val});

  // |a - b| < 2^SW, so the magnitude fits the sample width.
  assign diff_neg = -diff_q;
  assign mag      = diff_q[SW] ? diff_neg[SW-1:0] : diff_q[SW-1:0];
  assign sq_d     = (2*SW)'(mag) * (2*SW)'(mag);

  // Saturating accumulate: any carry beyond the accumulator pins it at max.
  assign sum_ext = SUM_W'(acc_q) + SUM_W'(sq_q);
  assign sum_ovf = |sum_ext[SUM_W-1:ACC_WIDTH];

  assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    acc_d      = acc_q;
    ovf_d      = ovf_q;
    sqrt_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_SQUARE;
      end
      ST_SQUARE: begin
        state_d = ST_ACCUM;
      end
      ST_ACCUM: begin
        if (sum_ovf) begin
          acc_d = '1;
          ovf_d = 1'b1;
        end else begin
          acc_d = sum_ext[ACC_WIDTH-1:0];
        end
        if (last_q) begin
          sqrt_start = 1'b1;
          state_d    = ST_ROOT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_ROOT: begin
        if (sqrt_stat.done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        // Hold until the output register is free, then clear the sum.
        if (emit_fire) begin
          acc_d   = '0;
          ovf_d   = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Root unit, shared over all bits of the result
  // ---------------------------------------------------------------------
  ed_sqrt #(
    .OP_WIDTH (ACC_WIDTH)
  ) u_sqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sqrt_start),
    .operand_i (acc_d),
    .stat_o    (sqrt_stat),
    .root_o    (root)
  );

  // Clamp a root that is wider than the distance field.
  generate
    if (RW > DW) begin : g_clamp
      assign root_clamp   = |root[RW-1:DW];
      assign dist_clamped = root_clamp ? '1 : root[DW-1:0];
    end else begin : g_noclamp
      assign root_clamp   = 1'b0;
      assign dist_clamped = DW'(root);
    end
  endgenerate

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) out_valid_d = 1'b0;
    if (emit_fire) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      diff_q <= diff_d;
      last_q <= s_axis_tlast;
    end
    if (state_q == ST_SQUARE) sq_q <= sq_d;
    if (emit_fire) begin
      dist_q <= dist_clamped;
      sat_q  <= ovf_q || root_clamp;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = dist_q;
  assign m_axis_tuser  = sat_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // The root unit runs only while the block refuses new requests.
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_stat.busy |-> !s_axis_tready)
    else $error("root unit busy while input ready");

  // The root finishes only while the sequencer waits for it.
  a_done_in_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_stat.done |-> (state_q == ST_ROOT))
    else $error("root done outside root wait");

  // An emitted result shows up and leaves a cleared sum behind.
  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |=> (m_axis_tvalid && (acc_q == '0) && !ovf_q))
    else $error("emit did not present result or clear sum");

  // The root starts only for a final pair, in the accumulate step after its square step.
  a_start_from_accum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_start |-> (last_q && $past(state_q) == ST_SQUARE))
    else $error("root started without a final pair");

endmodule

// ===== hw/rtl/ed_sqrt.sv =====
// Iterative floor square root, one result bit per cycle (restoring method).
// Depends on ed_pkg for the status struct.
module ed_sqrt #(
  parameter int unsigned OP_WIDTH = 48
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [OP_WIDTH-1:0]       operand_i,
  output ed_pkg::sqrt_stat_t        stat_o,
  output logic [(OP_WIDTH+1)/2-1:0] root_o
);

  localparam int unsigned RW = (OP_WIDTH + 1) / 2;
  localparam int unsigned CW = $clog2(RW + 1);

  logic [2*RW-1:0] x_q, x_d;
  logic [RW+1:0]   rem_q, rem_d;
  logic [RW-1:0]   root_q, root_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;

  logic [RW+3:0]   rem_sh;
  logic [RW+3:0]   trial;
  logic [RW+3:0]   diff;
  logic            take;

  // Bring down the next two operand bits and test root*4+1 against the shifted remainder.
  assign rem_sh = {rem_q, x_q[2*RW-1 -: 2]};
  assign trial  = (RW+4)'({root_q, 2'b01});
  assign take   = (rem_sh >= trial);
  assign diff   = rem_sh - trial;

  always_comb begin
    x_d    = x_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d    = (2*RW)'(operand_i);
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CW'(RW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      x_d    = x_q << 2;
      rem_d  = take ? diff[RW+1:0] : rem_sh[RW+1:0];
      root_d = {root_q[RW-2:0], take};
      cnt_d  = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign root_o      = root_q;

endmodule

// ===== tb/euclidean_distance_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for euclidean_distance: streams element pairs, predicts
// each distance and saturation flag, and checks every result in order.
// Depends on ed_pkg and euclidean_distance.
module euclidean_distance_tb;

  localparam int unsigned ACC_W = 48;
  localparam logic [ACC_W-1:0] ACC_MAX = '1;
  localparam int unsigned STALL_LIMIT = 1000;
  // Length of the long vector of max-magnitude differences.
  localparam int unsigned LONG_LEN = 64;

  // One request on the slave side.
  typedef struct packed {
    logic [15:0] a_value;
    logic [15:0] b_value;
    logic        last;
  } pair_t;

  // One result on the master side.
  typedef struct packed {
    logic [ed_pkg::DIST_W-1:0] distance;
    logic                      saturated;
  } dist_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  // [15:0] a_value, [31:16] b_value
  logic [31:0]               s_axis_tdata = '0;
  logic                      s_axis_tlast = 1'b0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  // [23:0] distance
  logic [ed_pkg::DIST_W-1:0] m_axis_tdata;
  // [0] saturated
  logic                      m_axis_tuser;

  pair_t pair_q[$];   // requests not yet presented
  dist_t dist_q[$];   // distances owed by the block, oldest first

  // Predictor state: running sum of squares and sticky overflow flag.
  logic [ACC_W-1:0] sum_q = '0;
  logic             ovf_q = 1'b0;

  logic in_fire_q = 1'b0;
  bit   idle_en = 1'b1;
  int   burst_left = 1;
  int   gap_left = 0;
  int   stall_left = 0;
  int   err_count = 0;
  int   quiet_cycles = 0;

  euclidean_distance u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  // Floor square root, one result bit per step from the top down.
  function automatic logic [ed_pkg::DIST_W-1:0] floor_root(logic [ACC_W-1:0] x);
    logic [ed_pkg::DIST_W-1:0] r;
    logic [ed_pkg::DIST_W-1:0] t;
    r = '0;
    for (int i = ed_pkg::DIST_W - 1; i >= 0; i--) begin
      t = r | (ed_pkg::DIST_W'(1) << i);
      if (ACC_W'(t) * ACC_W'(t) <= x) r = t;
    end
    return r;
  endfunction

  // Fold one accepted pair into the running sum; on last, owe one distance.
  function automatic void accumulate_pair(pair_t p);
    logic signed [16:0] diff;
    logic [16:0]        mag;
    logic [ACC_W-1:0]   sq;
    logic [ACC_W:0]     total;
    dist_t              res;
    diff  = $signed({p.a_value[15], p.a_value}) - $signed({p.b_value[15], p.b_value});
    mag   = diff[16] ? 17'(-diff) : 17'(diff);
    sq    = ACC_W'(mag) * ACC_W'(mag);
    total = {1'b0, sum_q} + {1'b0, sq};
    // Clamp at the top of the accumulator and remember it until the result.
    if (total > {1'b0, ACC_MAX}) begin
      sum_q = ACC_MAX;
      ovf_q = 1'b1;
    end else begin
      sum_q = total[ACC_W-1:0];
    end
    if (p.last) begin
      res.distance  = floor_root(sum_q);
      res.saturated = ovf_q;
      dist_q.push_back(res);
      sum_q = '0;
      ovf_q = 1'b0;
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  task automatic push_pair(logic [15:0] a, logic [15:0] b, logic last);
    pair_t p;
    p.a_value = a;
    p.b_value = b;
    p.last    = last;
    pair_q.push_back(p);
  endtask

  // Mostly full-range samples, with a share of small values and extremes.
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
      1, 2:    return 16'($signed($urandom_range(0, 32)) - 16);
      default: return 16'($urandom);
    endcase
  endfunction

  // Queue whole vectors of random length until about n pairs are pending.
  task automatic add_random_vectors(int n);
    int cnt;
    int len;
    cnt = 0;
    while (cnt < n) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (int k = 0; k < len; k++) push_pair(pick_sample(), pick_sample(), k == len - 1);
      cnt += len;
    end
  endtask

  // Hold until every request is taken and every owed distance has come back.
  task automatic wait_drained();
    while (pair_q.size() != 0 || s_axis_tvalid || dist_q.size() != 0) @(posedge clk_i);
  endtask

  // Driver: present requests in bursts of random length, with random gaps while idle_en is set.
  // Hold a presented request until it is taken; only then advance or idle.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire_q) begin
      if (gap_left != 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pair_q.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pair_q[0].b_value, pair_q[0].a_value};
        s_axis_tlast  <= pair_q[0].last;
        void'(pair_q.pop_front());
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 16);
          if (!idle_en) gap_left = 0;
          else if ($urandom_range(0, 3) == 0) gap_left = $urandom_range(4, 12);
          else gap_left = $urandom_range(0, 3);
        end else begin
          burst_left--;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: mostly ready, dropping ready for stall windows of random length while idle_en is set.
  always @(negedge clk_i) begin
    if (!idle_en) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 12);
    end
  end

  // Monitor: predict on every accepted request, check every accepted result.
  // The watchdog ends the run if nothing moves for too long.
  always @(posedge clk_i) begin
    in_fire_q <= s_axis_tvalid && s_axis_tready;
    if (s_axis_tvalid && s_axis_tready) begin
      accumulate_pair('{a_value: s_axis_tdata[15:0], b_value: s_axis_tdata[31:16],
                        last: s_axis_tlast});
    end
    if (m_axis_tvalid && m_axis_tready) begin
      if (dist_q.size() == 0) begin
        report_mismatch("unexpected result", 32'(m_axis_tdata), 32'(0));
      end else begin
        if (m_axis_tdata !== dist_q[0].distance)
          report_mismatch("distance", 32'(m_axis_tdata), 32'(dist_q[0].distance));
        if (m_axis_tuser !== dist_q[0].saturated)
          report_mismatch("saturated", 32'(m_axis_tuser), 32'(dist_q[0].saturated));
        void'(dist_q.pop_front());
      end
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero distance, extreme differences both ways, equal extremes,
    // truncated roots, exact roots, and multi-pair vectors.
    idle_en = 1'b1;
    push_pair(16'h0000, 16'h0000, 1'b1);
    push_pair(16'h7FFF, 16'h8000, 1'b1);
    push_pair(16'h8000, 16'h7FFF, 1'b1);
    push_pair(16'h8000, 16'h8000, 1'b1);
    push_pair(16'h7FFF, 16'h7FFF, 1'b1);
    push_pair(16'h7FFF, 16'h7FFF, 1'b0);
    push_pair(16'h0001, 16'h0000, 1'b0);
    push_pair(16'h0000, 16'h0001, 1'b1);
    push_pair(16'h0003, 16'h0000, 1'b0);
    push_pair(16'h0000, 16'h0004, 1'b1);
    push_pair(16'h0003, 16'h0000, 1'b1);
    push_pair(16'hFFFF, 16'h0001, 1'b1);
    push_pair(16'h5555, 16'hAAAA, 1'b0);
    push_pair(16'hAAAA, 16'h5555, 1'b0);
    push_pair(16'h8000, 16'h0000, 1'b0);
    push_pair(16'h0000, 16'h7FFF, 1'b1);
    push_pair(16'h0100, 16'hFF00, 1'b1);
    wait_drained();

    // Long vector of max-magnitude differences for a wide sum, then make sure
    // the next vector starts from a clean sum. No idling keeps this quick.
    idle_en = 1'b0;
    for (int i = 0; i < LONG_LEN; i++) push_pair(16'h7FFF, 16'h8000, i == LONG_LEN - 1);
    push_pair(16'h0001, 16'h0000, 1'b1);
    wait_drained();

    // Random vectors with idling on both sides, then a stretch without.
    idle_en = 1'b1;
    add_random_vectors(420);
    wait_drained();
    idle_en = 1'b0;
    add_random_vectors(180);
    wait_drained();

    // Let any stray result surface before the verdict.
    repeat (64) @(posedge clk_i);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/ed_pkg.sv
hw/rtl/ed_sqrt.sv
hw/rtl/euclidean_distance.sv
tb/euclidean_distance_tb.sv
